// ===== src/mmio_region_decoder_macros.svh =====
// Assertion helpers for the region decoder.
`ifndef MMIO_REGION_DECODER_MACROS_SVH
`define MMIO_REGION_DECODER_MACROS_SVH

// Implication, checked out of reset.
`define MRD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must never be seen out of reset.
`define MRD_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

// ===== src/mrd_pkg.sv =====
`default_nettype none
package mrd_pkg;

   localparam int MAX_REGIONS = 16;
   localparam logic [31:0] SELF_BASE = 32'h0000_0000;
   localparam logic [31:0] SELF_LENGTH = 32'd11;
   localparam int IDX_W = $clog2(MAX_REGIONS);
   localparam int CNT_W = IDX_W + 1;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_ADD    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_BAD_DEVICE = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] address;
      logic [31:0] region_start;
      logic [31:0] region_length;
      logic [15:0] device_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [3:0]  region_index;
      logic        is_self;
      logic [15:0] owner_device;
      logic [63:0] offset;
   } rsp_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] length;
      logic        is_self;
      logic [15:0] owner;
   } region_type;

   // Token that walks the cell chain, one cell per cycle while the output is not stalled.
   typedef struct packed {
      logic [1:0]       op;
      logic [63:0]      address;
      logic [CNT_W-1:0] count;
      logic             wr;
      logic [IDX_W-1:0] wr_index;
      region_type       region;
      logic [1:0]       status;
      logic             hit;
      logic [IDX_W-1:0] match_index;
      logic             is_self;
      logic [15:0]      owner;
      logic [31:0]      match_start;
   } flow_type;

   function automatic logic [3:0] index4(input logic [IDX_W-1:0] idx);
      logic [IDX_W+3:0] wide;
      wide = {4'b0000, idx};
      return wide[3:0];
   endfunction

endpackage
`default_nettype wire

// ===== src/mrd_admit.sv =====
`default_nettype none
module mrd_admit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [15:0]      csr_wr_data,
   input  wire mrd_pkg::req_type req_payload,
   input  wire logic             accept,
   output mrd_pkg::flow_type     flow_out
);
   import mrd_pkg::*;

   logic [15:0]      device_count_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   flow_type         flow;

   always_comb begin
      count_in = count_ff;
      flow = '0;
      flow.op = req_payload.operation;
      flow.address = req_payload.address;
      flow.wr_index = count_ff[IDX_W-1:0];
      flow.region.start = req_payload.region_start;
      flow.region.length = req_payload.region_length;
      flow.region.is_self = 1'b0;
      flow.region.owner = req_payload.device_id;
      flow.status = ST_OK;
      case (req_payload.operation)
         OP_LOOKUP: begin
         end
         OP_CLEAR: begin
            count_in = CNT_W'(1);
         end
         OP_ADD: begin
            if (req_payload.device_id >= device_count_ff) begin
               flow.status = ST_BAD_DEVICE;
            end else if (count_ff >= CNT_W'(MAX_REGIONS)) begin
               flow.status = ST_FULL;
            end else begin
               flow.wr = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
      flow.count = count_in;
   end

   assign flow_out = flow;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_count_ff <= '0;
         count_ff <= CNT_W'(1);
      end else begin
         if (csr_wr_en) begin
            device_count_ff <= csr_wr_data;
         end
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

endmodule
`default_nettype wire

// ===== src/mrd_cell.sv =====
`default_nettype none
module mrd_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [mrd_pkg::IDX_W-1:0] cell_index,
   input  wire logic                      advance,
   input  wire logic                      in_valid,
   input  wire mrd_pkg::flow_type         in_flow,
   output logic                           out_valid,
   output mrd_pkg::flow_type              out_flow
);
   import mrd_pkg::*;

   region_type entry_ff;
   logic       valid_ff;
   flow_type   flow_ff;
   flow_type   flow_in;
   logic [32:0] span_end;
   logic        in_range;
   logic        live;
   logic        write;

   always_comb begin
      span_end = {1'b0, entry_ff.start} + {1'b0, entry_ff.length};
      in_range = (in_flow.address[63:33] == 31'd0)
                 && (in_flow.address[32:0] >= {1'b0, entry_ff.start})
                 && (in_flow.address[32:0] < span_end);
      live = {1'b0, cell_index} < in_flow.count;
      flow_in = in_flow;
      if (in_valid && (in_flow.op == OP_LOOKUP) && !in_flow.hit && live && in_range) begin
         flow_in.hit = 1'b1;
         flow_in.match_index = cell_index;
         flow_in.is_self = entry_ff.is_self;
         flow_in.owner = entry_ff.is_self ? 16'd0 : entry_ff.owner;
         flow_in.match_start = entry_ff.start;
      end
      write = advance && in_valid && (in_flow.op == OP_ADD) && in_flow.wr
              && (in_flow.wr_index == cell_index);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         entry_ff.start <= SELF_BASE;
         entry_ff.length <= SELF_LENGTH;
         entry_ff.is_self <= 1'b1;
         entry_ff.owner <= 16'd0;
      end else if (advance) begin
         valid_ff <= in_valid;
         flow_ff <= flow_in;
         if (write) begin
            entry_ff <= in_flow.region;
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_flow = flow_ff;

endmodule
`default_nettype wire

// ===== src/mmio_region_decoder.sv =====
// Region decoder: a row of region cells, one table entry per cell. Every transfer
// (lookup, clear or add) walks the row one cell per cycle while the output is not
// stalled, so one item is taken each cycle unless rsp_stall holds the row; each
// result passes each cell register and then the output register, in order. The
// region count is kept at the entry of the chain, so a clear or add takes effect
// for the very next transfer. No clearing pass is run after reset.
`default_nettype none
`include "mmio_region_decoder_macros.svh"
module mmio_region_decoder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [15:0]      csr_wr_data,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mrd_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mrd_pkg::rsp_type      rsp_payload
);
   import mrd_pkg::*;

   logic     advance;
   logic     accept;
   logic     valid_chain [0:MAX_REGIONS];
   flow_type flow_chain  [0:MAX_REGIONS];
   flow_type last;
   logic     rsp_valid_ff;
   rsp_type  rsp_payload_ff;
   rsp_type  rsp_payload_in;

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept = req_valid && advance;
   assign valid_chain[0] = accept;

   mrd_admit u_admit (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_payload),
      .accept      (accept),
      .flow_out    (flow_chain[0])
   );

   for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
      mrd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .advance    (advance),
         .in_valid   (valid_chain[i]),
         .in_flow    (flow_chain[i]),
         .out_valid  (valid_chain[i+1]),
         .out_flow   (flow_chain[i+1])
      );
   end

   assign last = flow_chain[MAX_REGIONS];

   always_comb begin
      rsp_payload_in.status = last.status;
      rsp_payload_in.hit = last.hit;
      rsp_payload_in.region_index = index4(last.match_index);
      rsp_payload_in.is_self = last.is_self;
      rsp_payload_in.owner_device = last.owner;
      if (last.op == OP_LOOKUP) begin
         rsp_payload_in.offset = last.hit ? last.address - {32'd0, last.match_start}
                                          : last.address;
      end else begin
         rsp_payload_in.offset = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_chain[MAX_REGIONS];
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `MRD_ASSERT_NEVER(a_stall_holds_input, rsp_valid && rsp_stall && !req_stall,
                     "input taken while output blocked")
   `MRD_ASSERT_IMP(a_hit_ok, rsp_valid && rsp_payload.hit, rsp_payload.status == ST_OK,
                   "hit with error status")
   `MRD_ASSERT_IMP(a_self_entry, rsp_valid && rsp_payload.is_self,
                   rsp_payload.hit && (rsp_payload.region_index == 4'd0)
                   && (rsp_payload.owner_device == 16'd0), "self window result malformed")

endmodule
`default_nettype wire
